// ===== design/nat_ckrw_pkg.sv =====
package nat_ckrw_pkg;

  localparam int HELD_WORDS = 5;
  localparam int HOLD_IDX_W = $clog2(HELD_WORDS - 1);
  localparam int RUN_CNT_W  = $clog2(HELD_WORDS + 1);

  localparam logic [4:0] POS_ADDR_WORD = 5'(HELD_WORDS - 1);
  localparam logic [4:0] POS_MAX       = 5'd31;
  localparam logic [4:0] TCP_CSUM_OFS  = 5'd4;
  localparam logic [4:0] UDP_CSUM_OFS  = 5'd1;
  localparam logic [3:0] IHL_MIN       = 4'd5;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  // configuration register indexes
  localparam logic CFG_NEW_ADDRESS      = 1'b0;
  localparam logic CFG_TRANSLATE_SOURCE = 1'b1;

  typedef enum logic [1:0] {
    KIND_OTHER = 2'd0,
    KIND_TCP   = 2'd1,
    KIND_UDP   = 2'd2
  } kind_t;

  typedef struct packed {
    logic [31:0] in_word;
    logic        in_last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_word;
    logic        packet_end;
    logic        run_end;
  } out_item_t;

  typedef logic [RUN_CNT_W-1:0] run_cnt_t;

  // one queue entry: a run of 1..HELD_WORDS output words
  typedef struct packed {
    logic [HELD_WORDS-1:0][31:0] words;
    run_cnt_t                    cnt;
    logic                        last;
  } job_t;

  function automatic logic [31:0] fold16(input logic [31:0] x);
    return {16'h0000, x[31:16]} + {16'h0000, x[15:0]};
  endfunction

  // incremental one's complement update, zero checksum left alone
  function automatic logic [15:0] patch_sum(input logic [15:0] sum,
                                            input logic [31:0] old_a,
                                            input logic [31:0] new_a);
    logic [31:0] fo;
    logic [31:0] fn;
    logic [31:0] s;
    fo = fold16(fold16(~old_a));
    fn = fold16(fold16(~new_a));
    s  = 32'h0001_0000 + ({16'h0000, sum} - 32'h0000_0001) - fo + fn;
    s  = fold16(fold16(s));
    return (sum == 16'h0000) ? 16'h0000 : s[15:0];
  endfunction

endpackage

// ===== design/nat_ckrw_front.sv =====
module nat_ckrw_front (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  nat_ckrw_pkg::in_item_t in_data,
  input  logic                   cfg_we,
  input  logic                   cfg_index,
  input  logic [31:0]            cfg_wdata,
  input  logic                   q_full,
  output logic                   push,
  output nat_ckrw_pkg::job_t     push_job
);
  import nat_ckrw_pkg::*;

  logic [31:0] new_addr_r;
  logic        xlate_src_r;
  logic [31:0] held_r [HELD_WORDS-1];
  logic [4:0]  pos_r;
  logic [3:0]  ihl_r;
  kind_t       kind_r;
  logic [31:0] old_addr_r;
  logic        changed_r;

  logic                        accept;
  logic [31:0]                 w;
  logic                        last;
  logic [HELD_WORDS-1:0][31:0] hdr;
  logic [HELD_WORDS-1:0][31:0] patched;
  logic [3:0]                  ihl;
  logic [7:0]                  proto;
  logic                        first_frag;
  logic [31:0]                 old_a;
  logic                        do_nat;
  kind_t                       kind_nxt;
  logic                        tcp_hit;
  logic                        udp_hit;
  logic [15:0]                 xp_sum;
  logic [15:0]                 xp_new;
  logic [31:0]                 xw;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign w        = in_data.in_word;
  assign last     = in_data.in_last;

  // header decode at the address word
  always_comb begin
    for (int i = 0; i < HELD_WORDS - 1; i++) begin
      hdr[i] = held_r[i];
    end
    hdr[HELD_WORDS-1] = w;
    ihl        = hdr[0][27:24];
    proto      = hdr[2][23:16];
    first_frag = (hdr[1][12:0] == 13'd0);
    old_a      = xlate_src_r ? hdr[3] : hdr[4];
    do_nat     = (ihl >= IHL_MIN) && (old_a != new_addr_r);
    patched    = hdr;
    kind_nxt   = KIND_OTHER;
    if (do_nat) begin
      if (xlate_src_r) begin
        patched[3] = new_addr_r;
      end else begin
        patched[4] = new_addr_r;
      end
      patched[2][15:0] = patch_sum(hdr[2][15:0], old_a, new_addr_r);
      if (first_frag) begin
        if (proto == PROTO_TCP) begin
          kind_nxt = KIND_TCP;
        end else if (proto == PROTO_UDP) begin
          kind_nxt = KIND_UDP;
        end
      end
    end
  end

  // transport checksum patch on pass-through words, one shared update
  always_comb begin
    tcp_hit = 1'b0;
    udp_hit = 1'b0;
    if (changed_r) begin
      case (kind_r)
        KIND_TCP: tcp_hit = (pos_r == {1'b0, ihl_r} + TCP_CSUM_OFS);
        KIND_UDP: udp_hit = (pos_r == {1'b0, ihl_r} + UDP_CSUM_OFS);
        default: ;
      endcase
    end
    xp_sum = tcp_hit ? w[31:16] : w[15:0];
    xp_new = patch_sum(xp_sum, old_addr_r, new_addr_r);
    xw     = w;
    if (tcp_hit) begin
      xw[31:16] = xp_new;
    end else if (udp_hit) begin
      xw[15:0] = xp_new;
    end
  end

  always_comb begin
    push_job      = '0;
    push_job.last = last;
    push          = 1'b0;
    if (pos_r < POS_ADDR_WORD) begin
      // early end releases what is held, unchanged
      push = accept && last;
      for (int i = 0; i < HELD_WORDS - 1; i++) begin
        push_job.words[i] = (HOLD_IDX_W'(i) == pos_r[HOLD_IDX_W-1:0]) ? w : held_r[i];
      end
      push_job.cnt = RUN_CNT_W'(pos_r) + run_cnt_t'(1);
    end else if (pos_r == POS_ADDR_WORD) begin
      push           = accept;
      push_job.words = patched;
      push_job.cnt   = run_cnt_t'(HELD_WORDS);
    end else begin
      push              = accept;
      push_job.words[0] = xw;
      push_job.cnt      = run_cnt_t'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (pos_r < POS_ADDR_WORD)) begin
      held_r[pos_r[HOLD_IDX_W-1:0]] <= w;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      new_addr_r  <= '0;
      xlate_src_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NEW_ADDRESS:      new_addr_r  <= cfg_wdata;
        CFG_TRANSLATE_SOURCE: xlate_src_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r      <= '0;
      ihl_r      <= '0;
      kind_r     <= KIND_OTHER;
      old_addr_r <= '0;
      changed_r  <= 1'b0;
    end else if (accept) begin
      if (last) begin
        pos_r      <= '0;
        ihl_r      <= '0;
        kind_r     <= KIND_OTHER;
        old_addr_r <= '0;
        changed_r  <= 1'b0;
      end else begin
        if (pos_r != POS_MAX) begin
          pos_r <= pos_r + 5'd1;
        end
        if (pos_r == POS_ADDR_WORD) begin
          ihl_r     <= ihl;
          changed_r <= do_nat;
          kind_r    <= kind_nxt;
          if (do_nat) begin
            old_addr_r <= old_a;
          end
        end
      end
    end
  end

endmodule

// ===== design/nat_ckrw_queue.sv =====
module nat_ckrw_queue #(
  parameter int DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  nat_ckrw_pkg::job_t push_job,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output nat_ckrw_pkg::job_t head
);
  import nat_ckrw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign q_valid = (count_r != '0);
  assign head    = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CNT_W'(1);
      end
    end
  end

endmodule

// ===== design/nat_ckrw_back.sv =====
module nat_ckrw_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    q_valid,
  input  nat_ckrw_pkg::job_t      head,
  output logic                    pop,
  output logic                    out_valid,
  input  logic                    out_stall,
  output nat_ckrw_pkg::out_item_t out_data
);
  import nat_ckrw_pkg::*;

  run_cnt_t  idx_r;
  logic      out_valid_r;
  out_item_t out_data_r;
  logic      load;
  logic      emit;
  logic      is_end;

  assign load      = !out_valid_r || !out_stall;
  assign emit      = q_valid && load;
  assign is_end    = ((idx_r + run_cnt_t'(1)) == head.cnt);
  assign pop       = emit && is_end;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r.out_word   <= head.words[idx_r];
      out_data_r.packet_end <= head.last && is_end;
      out_data_r.run_end    <= is_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= q_valid;
      end
      if (emit) begin
        idx_r <= is_end ? '0 : idx_r + run_cnt_t'(1);
      end
    end
  end

endmodule

// ===== design/ipv4_nat_checksum_rewriter.sv =====
// With an empty queue a pass-through word is written into the queue and then into the output
// register, from which it shows at the output.
// Header words 0..3 are held; the address word releases the 5 patched header
// words, one per cycle from the output stage while out_stall is low.
// The input takes 1 word per cycle, except that with the default queue depth of 2 the input
// stalls while the header drains and the queue is full.
module ipv4_nat_checksum_rewriter #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  nat_ckrw_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  logic                    out_stall,
  output nat_ckrw_pkg::out_item_t out_data,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [31:0]             cfg_wdata
);
  import nat_ckrw_pkg::*;

  // Reset: synchronous, active low; clears packet state, queue and config registers.

  logic push;
  job_t push_job;
  logic q_full;
  logic pop;
  logic q_valid;
  job_t head;

  nat_ckrw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  nat_ckrw_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .q_valid  (q_valid),
    .head     (head)
  );

  nat_ckrw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ===== design/nat_ckrw_checker.sv =====
module nat_ckrw_checker (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_stall,
  input logic                    out_valid,
  input logic                    out_stall,
  input nat_ckrw_pkg::out_item_t out_data
);
  import nat_ckrw_pkg::*;

  // stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("output changed while stalled");

  // a packet end always closes the run of its input word
  a_end_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!out_data.packet_end || out_data.run_end))
    else $error("packet_end without run_end");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

  a_reset_in: assert property (@(posedge clk)
    !rst_n |=> !in_stall)
    else $error("input stalled after reset");

endmodule

bind ipv4_nat_checksum_rewriter nat_ckrw_checker u_nat_ckrw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ===== tb/ipv4_nat_checksum_rewriter_test.sv =====
`timescale 1ns / 1ps

module ipv4_nat_checksum_rewriter_test;
  import nat_ckrw_pkg::*;

  localparam int ITEM_TARGET = 230;
  localparam int CALM_TAIL   = 40;
  localparam int STUCK_LIMIT = 1000;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_we    = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  ipv4_nat_checksum_rewriter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #2 clk = ~clk;

  // stimulus plumbing
  in_item_t  pkt_q[$];
  in_item_t  word_feed[$];
  out_item_t rewritten_q[$];
  logic      in_taken = 1'b0;
  int        feed_gap = 0;
  int        stall_left = 0;
  bit        idle_on = 1'b1;
  bit        quiet = 1'b0;
  logic [31:0] set_addr = '0;

  // scoreboard counters
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  int items_queued = 0;
  int pkt_count = 0;
  int reg_writes = 0;
  int stuck_cycles = 0;

  // predictor state: registers
  logic [31:0] cfg_addr;
  logic        xlate_src;
  // predictor state: per packet
  logic [31:0] hdr_held [5];
  logic [4:0]  hdr_pos;
  logic [3:0]  pkt_ihl;
  kind_t       pkt_kind;
  logic        pkt_first;
  logic [31:0] pkt_old;
  logic        pkt_changed;

  function automatic logic [31:0] fold_half(input logic [31:0] x);
    return 32'(x[31:16]) + 32'(x[15:0]);
  endfunction

  // RFC 1624 style one's complement adjustment; zero checksum means "none"
  function automatic logic [15:0] adjust_csum(input logic [15:0] sum,
                                              input logic [31:0] from_a,
                                              input logic [31:0] to_a);
    logic [31:0] acc;
    if (sum == 16'h0000) return 16'h0000;
    acc = 32'h0001_0000 + 32'(sum) - 32'd1 - fold_half(fold_half(~from_a))
          + fold_half(fold_half(~to_a));
    acc = fold_half(fold_half(acc));
    return acc[15:0];
  endfunction

  task automatic drop_packet_state();
    hdr_pos     = '0;
    pkt_ihl     = '0;
    pkt_kind    = KIND_OTHER;
    pkt_first   = 1'b0;
    pkt_old     = '0;
    pkt_changed = 1'b0;
  endtask

  task automatic nat_rewrite_predict(input in_item_t it);
    logic [31:0] w;
    logic [31:0] prev;
    logic [7:0]  proto;
    logic [2:0]  slot;
    int          i;
    out_item_t   run[$];
    out_item_t   o;
    w = it.in_word;
    o.packet_end = 1'b0;
    o.run_end    = 1'b0;
    if (hdr_pos < 5'd4) begin
      hdr_held[hdr_pos[2:0]] = w;
      if (it.in_last) begin
        for (i = 0; i <= int'(hdr_pos); i++) begin
          o.out_word = hdr_held[i];
          run.push_back(o);
        end
      end
    end else if (hdr_pos == 5'd4) begin
      hdr_held[4] = w;
      proto       = hdr_held[2][23:16];
      slot        = xlate_src ? 3'd3 : 3'd4;
      prev        = hdr_held[slot];
      pkt_ihl     = hdr_held[0][27:24];
      pkt_first   = (hdr_held[1][12:0] == 13'h0000);
      pkt_changed = 1'b0;
      pkt_kind    = KIND_OTHER;
      if (pkt_ihl >= 4'd5 && prev != cfg_addr) begin
        pkt_changed = 1'b1;
        pkt_old     = prev;
        hdr_held[slot] = cfg_addr;
        hdr_held[2][15:0] = adjust_csum(hdr_held[2][15:0], prev, cfg_addr);
        if (pkt_first && proto == PROTO_TCP) pkt_kind = KIND_TCP;
        else if (pkt_first && proto == PROTO_UDP) pkt_kind = KIND_UDP;
      end
      for (i = 0; i < 5; i++) begin
        o.out_word = hdr_held[i];
        run.push_back(o);
      end
    end else begin
      // transport patch uses the address register as it stands now
      if (pkt_changed) begin
        if (pkt_kind == KIND_TCP && hdr_pos == {1'b0, pkt_ihl} + 5'd4)
          w[31:16] = adjust_csum(w[31:16], pkt_old, cfg_addr);
        else if (pkt_kind == KIND_UDP && hdr_pos == {1'b0, pkt_ihl} + 5'd1)
          w[15:0] = adjust_csum(w[15:0], pkt_old, cfg_addr);
      end
      o.out_word = w;
      run.push_back(o);
    end
    if (run.size() > 0) begin
      run[run.size() - 1].run_end    = 1'b1;
      run[run.size() - 1].packet_end = it.in_last;
    end
    foreach (run[i]) rewritten_q.push_back(run[i]);
    if (it.in_last) drop_packet_state();
    else if (hdr_pos != 5'd31) hdr_pos = hdr_pos + 5'd1;
  endtask

  // monitor: register writes, result checking, input prediction
  always @(posedge clk) begin
    out_item_t want;
    in_taken <= in_valid && !in_stall;
    if (!rst_n) begin
      cfg_addr  = '0;
      xlate_src = 1'b0;
      foreach (hdr_held[i]) hdr_held[i] = '0;
      drop_packet_state();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NEW_ADDRESS:      cfg_addr  = cfg_wdata;
          CFG_TRANSLATE_SOURCE: xlate_src = cfg_wdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        words_out++;
        if (rewritten_q.size() == 0) begin
          errors++;
          $display("%0t unexpected transaction: expected none, actual %08h end=%b run=%b",
                   $time, out_data.out_word, out_data.packet_end, out_data.run_end);
        end else begin
          want = rewritten_q.pop_front();
          if (out_data.out_word !== want.out_word) begin
            errors++;
            $display("%0t out_word mismatch: expected %08h, actual %08h",
                     $time, want.out_word, out_data.out_word);
          end
          if (out_data.packet_end !== want.packet_end) begin
            errors++;
            $display("%0t packet_end mismatch: expected %b, actual %b",
                     $time, want.packet_end, out_data.packet_end);
          end
          if (out_data.run_end !== want.run_end) begin
            errors++;
            $display("%0t run_end mismatch: expected %b, actual %b",
                     $time, want.run_end, out_data.run_end);
          end
        end
      end
      if (in_valid && !in_stall) begin
        words_in++;
        nat_rewrite_predict(in_data);
      end
    end
  end

  // input driver: payload holds while stalled
  always @(negedge clk) begin
    if (!(in_valid && !in_taken)) begin
      if (feed_gap > 0) begin
        in_valid <= 1'b0;
        feed_gap--;
      end else if (word_feed.size() > 0) begin
        if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
          in_valid <= 1'b0;
          feed_gap = $urandom_range(0, 2);
        end else begin
          in_valid <= 1'b1;
          in_data  <= word_feed.pop_front();
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // random output backpressure in bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (idle_on && !quiet && $urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= STUCK_LIMIT) begin
      $display("%0t watchdog: no transaction for %0d cycles, %0d results outstanding",
               $time, stuck_cycles, rewritten_q.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // wait for the block to drain, plus margin for held header words
  task automatic wait_idle();
    do begin
      @(posedge clk);
      #1;
    end while (word_feed.size() != 0 || in_valid || rewritten_q.size() != 0);
    repeat (6) @(posedge clk);
    #1;
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] val);
    wait_idle();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    #1;
    if (idx == CFG_NEW_ADDRESS) set_addr = val;
    reg_writes++;
  endtask

  // tgt: 1 forces source = replacement address, 2 forces destination
  task automatic make_packet(input bit raw, input logic [3:0] ihl,
                             input logic [7:0] proto, input logic [12:0] frag,
                             input logic [15:0] csum, input int len, input int tgt);
    logic [31:0] w;
    in_item_t    it;
    int          k;
    for (k = 0; k < len; k++) begin
      w = $urandom();
      if (!raw) begin
        case (k)
          0: w[31:24] = {4'd4, ihl};
          1: w[12:0]  = frag;
          2: w[23:0]  = {proto, csum};
          3: if (tgt == 1) w = set_addr;
          4: if (tgt == 2) w = set_addr;
          default: begin
            case ($urandom_range(0, 9))
              0: w[31:16] = 16'h0000;
              1: w[15:0]  = 16'h0000;
              default: ;
            endcase
          end
        endcase
      end
      it.in_word = w;
      it.in_last = (k == len - 1);
      pkt_q.push_back(it);
    end
  endtask

  task automatic feed(input int n);
    int k;
    for (k = 0; k < n && pkt_q.size() > 0; k++) begin
      word_feed.push_back(pkt_q.pop_front());
      items_queued++;
    end
  endtask

  initial begin
    int          setting;
    int          sel;
    int          len;
    int          tgt;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [12:0] frag;
    logic [15:0] csum;
    setting = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    #1;

    // directed part
    write_reg(CFG_NEW_ADDRESS, 32'h0A00_0001);
    write_reg(CFG_TRANSLATE_SOURCE, 32'd0);
    make_packet(1'b0, 4'd5, PROTO_TCP, 13'h0, 16'h1234, 1, 0);
    feed(pkt_q.size());
    // header only, transport checksum never arrives
    make_packet(1'b0, 4'd5, PROTO_TCP, 13'h0, 16'hFFFF, 5, 0);
    feed(pkt_q.size());
    // translate_source flips while header words are held
    make_packet(1'b0, 4'd5, PROTO_UDP, 13'h0, 16'h8001, 7, 0);
    feed(3);
    write_reg(CFG_TRANSLATE_SOURCE, 32'd1);
    feed(pkt_q.size());
    make_packet(1'b0, 4'd4, PROTO_TCP, 13'h0, 16'h0F0F, 5, 0);
    feed(pkt_q.size());
    // address register changes between header and TCP checksum word
    make_packet(1'b0, 4'd5, PROTO_TCP, 13'h0, 16'hBEEF, 10, 0);
    feed(6);
    write_reg(CFG_NEW_ADDRESS, 32'hFFFF_FFFF);
    feed(pkt_q.size());
    pkt_count = 5;

    // random part
    while (items_queued < ITEM_TARGET) begin
      while (word_feed.size() > 2) begin
        @(posedge clk);
        #1;
      end
      quiet   = (items_queued >= ITEM_TARGET - CALM_TAIL);
      idle_on = ($urandom_range(0, 3) != 0);
      if (pkt_count % 6 == 5) begin
        case (setting % 3)
          0: write_reg(CFG_NEW_ADDRESS, 32'h0000_0000);
          1: write_reg(CFG_NEW_ADDRESS, 32'hFFFF_FFFF);
          default: write_reg(CFG_NEW_ADDRESS, $urandom());
        endcase
        write_reg(CFG_TRANSLATE_SOURCE, 32'((setting / 2) % 2));
        setting++;
      end
      if ($urandom_range(0, 4) == 0) begin
        len = $urandom_range(1, 8);
        make_packet(1'b1, '0, '0, '0, '0, len, 0);
      end else begin
        sel = $urandom_range(0, 9);
        if (sel < 7) ihl = 4'd5;
        else if (sel < 9) ihl = 4'($urandom_range(6, 15));
        else ihl = 4'($urandom_range(0, 4));
        case ($urandom_range(0, 2))
          0: proto = PROTO_TCP;
          1: proto = PROTO_UDP;
          default: proto = 8'($urandom());
        endcase
        frag = ($urandom_range(0, 3) == 0) ? 13'($urandom()) : 13'h0;
        case ($urandom_range(0, 9))
          0: csum = 16'h0000;
          1: csum = 16'hFFFF;
          default: csum = 16'($urandom());
        endcase
        case ($urandom_range(0, 5))
          0: tgt = 1;
          1: tgt = 2;
          default: tgt = 0;
        endcase
        if (pkt_count == 7) len = 36;  // runs the word counter into saturation
        else if ($urandom_range(0, 7) == 0) len = $urandom_range(1, int'(ihl) + 4);
        else len = int'(ihl) + $urandom_range(2, 8);
        make_packet(1'b0, ihl, proto, frag, csum, len, tgt);
      end
      if (len > 1 && $urandom_range(0, 7) == 0) begin
        feed($urandom_range(1, len - 1));
        if ($urandom_range(0, 1) == 1)
          write_reg(CFG_TRANSLATE_SOURCE, 32'($urandom_range(0, 1)));
        else
          write_reg(CFG_NEW_ADDRESS, $urandom());
      end
      feed(pkt_q.size());
      pkt_count++;
    end

    wait_idle();
    repeat (8) @(posedge clk);
    $display("Covered %0d packets (%0d words in, %0d words out) over %0d register writes,",
             pkt_count, words_in, words_out, reg_writes);
    $display("including held-header drains, short headers and mid-packet register changes.");
    if (errors == 0 && rewritten_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors, rewritten_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
